// File: design/npie_pkg.sv
package npie_pkg;

  localparam int unsigned FnW      = 4;
  localparam int unsigned OperandW = 32;
  localparam int unsigned NibW     = 4;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned NibCnt   = OperandW / NibW;
  localparam int unsigned PosW     = $clog2(NibCnt);
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 4;

  localparam logic [CfgIdxW-1:0] CfgIdxPrefix    = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgIdxNegPrefix = 1'b1;

  localparam logic [FnW-1:0] PrefixFnRst    = 4'd2;
  localparam logic [FnW-1:0] NegPrefixFnRst = 4'd6;

  typedef struct packed {
    logic [FnW-1:0]             function_code;
    logic signed [OperandW-1:0] operand;
  } enc_in_t;

  typedef struct packed {
    logic [ByteW-1:0] code_byte;
    logic             last_byte;
  } enc_out_t;

endpackage

// File: design/nibble_prefix_instruction_encoder.sv
// Encodes one direct instruction (function code and signed 32-bit operand) into its
// nibble-prefixed byte sequence, most significant prefix first, final byte flagged by
// last_byte. An instruction is 1 to 8 bytes, one plus the number of prefix bytes, sent
// back to back by the single byte serializer at the pipeline end. Three register stages
// ahead of it (input, nibble scan, length count) keep instructions queued, so the
// serializer runs back to back; busy rises while they are full and it has prefixes left.
// Bytes leave through an output register. Each byte is held on res_o for exactly one
// cycle with res_strobe_o high; the receiver cannot stall.
module nibble_prefix_instruction_encoder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  npie_pkg::enc_in_t         cmd_i,
  input  logic                      cfg_we_i,
  input  logic [npie_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [npie_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                      res_strobe_o,
  output npie_pkg::enc_out_t        res_o
);
  import npie_pkg::*;

  localparam int unsigned HiW = OperandW - NibW;

  logic [FnW-1:0] pre_fn_q, neg_fn_q;

  // stage 1: input register
  logic                s1_v_q;
  logic [FnW-1:0]      s1_fn_q;
  logic [OperandW-1:0] s1_op_q;

  // stage 2: operand inverted when negative, and nonzero nibble flags
  logic                s2_v_q;
  logic [FnW-1:0]      s2_fn_q;
  logic [NibW-1:0]     s2_low_q;
  logic                s2_neg_q;
  logic [HiW-1:0]      s2_hi_q;
  logic [NibCnt-1:1]   s2_nz_q;

  // stage 3: prefix count
  logic                s3_v_q;
  logic [FnW-1:0]      s3_fn_q;
  logic [NibW-1:0]     s3_low_q;
  logic                s3_neg_q;
  logic [HiW-1:0]      s3_hi_q;
  logic [PosW-1:0]     s3_cnt_q;

  // serializer
  logic                e_v_q;
  logic [FnW-1:0]      e_fn_q;
  logic [NibW-1:0]     e_low_q;
  logic                e_neg_q;
  logic [HiW-1:0]      e_hi_q;
  logic [PosW-1:0]     e_k_q;

  logic                out_v_q;
  enc_out_t            out_q;

  logic e_ready, s3_free, s2_free, s1_free, accept;
  logic [OperandW-1:0] s1_d;
  logic [NibCnt-1:1]   s1_nz;
  logic [PosW-1:0]     s2_n, s2_cnt;
  logic [PosW-1:0]     e_km1;
  logic [NibW-1:0]     e_nib;
  logic [FnW-1:0]      e_pfn;
  enc_out_t            out_d;

  assign e_ready = !e_v_q || (e_k_q == '0);
  assign s3_free = !s3_v_q || e_ready;
  assign s2_free = !s2_v_q || s3_free;
  assign s1_free = !s1_v_q || s2_free;
  assign busy    = !s1_free;
  assign accept  = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_fn_q <= PrefixFnRst;
      neg_fn_q <= NegPrefixFnRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgIdxPrefix:    pre_fn_q <= cfg_data_i[FnW-1:0];
        CfgIdxNegPrefix: neg_fn_q <= cfg_data_i[FnW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    s1_d = s1_op_q[OperandW-1] ? ~s1_op_q : s1_op_q;
    for (int i = 1; i < NibCnt; i++) begin
      s1_nz[i] = |s1_d[i*NibW +: NibW];
    end
  end

  always_comb begin
    s2_n = '0;
    for (int i = 1; i < NibCnt; i++) begin
      if (s2_nz_q[i]) s2_n = PosW'(i);
    end
    // negative operand always carries the negative prefix at position one
    s2_cnt = (s2_neg_q && s2_n == '0) ? PosW'(1) : s2_n;
  end

  always_comb begin
    e_km1 = e_k_q - PosW'(1);
    e_nib = e_hi_q[e_km1*NibW +: NibW];
    e_pfn = (e_neg_q && e_k_q == PosW'(1)) ? neg_fn_q : pre_fn_q;
    if (e_k_q == '0) begin
      out_d.code_byte = {e_fn_q, e_low_q};
      out_d.last_byte = 1'b1;
    end else begin
      out_d.code_byte = {e_pfn, e_nib};
      out_d.last_byte = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      e_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_free) s1_v_q <= accept;
      if (s2_free) s2_v_q <= s1_v_q;
      if (s3_free) s3_v_q <= s2_v_q;
      if (e_ready) e_v_q  <= s3_v_q;
      out_v_q <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_fn_q <= cmd_i.function_code;
      s1_op_q <= cmd_i.operand;
    end
    if (s2_free && s1_v_q) begin
      s2_fn_q  <= s1_fn_q;
      s2_low_q <= s1_op_q[NibW-1:0];
      s2_neg_q <= s1_op_q[OperandW-1];
      s2_hi_q  <= s1_d[OperandW-1:NibW];
      s2_nz_q  <= s1_nz;
    end
    if (s3_free && s2_v_q) begin
      s3_fn_q  <= s2_fn_q;
      s3_low_q <= s2_low_q;
      s3_neg_q <= s2_neg_q;
      s3_hi_q  <= s2_hi_q;
      s3_cnt_q <= s2_cnt;
    end
    if (e_ready && s3_v_q) begin
      e_fn_q  <= s3_fn_q;
      e_low_q <= s3_low_q;
      e_neg_q <= s3_neg_q;
      e_hi_q  <= s3_hi_q;
      e_k_q   <= s3_cnt_q;
    end else if (e_v_q && e_k_q != '0) begin
      e_k_q <= e_km1;
    end
    out_q <= out_d;
  end

  assign res_strobe_o = out_v_q;
  assign res_o        = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (s1_v_q && s2_v_q && s3_v_q && e_v_q))
    else $error("busy without a full pipeline");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && !res_o.last_byte) |=> res_strobe_o)
    else $error("gap inside an instruction byte sequence");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (e_v_q && e_k_q != '0) |=> (e_v_q && e_k_q == $past(e_k_q) - PosW'(1)))
    else $error("serializer position did not step down");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (e_v_q && e_k_q == '0) |=> (res_strobe_o && res_o.last_byte))
    else $error("final byte not flagged");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import npie_pkg::*;

  localparam int unsigned SettleCycles = 4;
  localparam int unsigned DrainCycles  = 20;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned PhaseItems   = 52;

  typedef enum logic [1:0] {
    EntItem,
    EntCfg,
    EntIdle
  } entry_kind_e;

  typedef struct {
    entry_kind_e          kind;
    enc_in_t              cmd;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  data;
    int unsigned          count;
  } stim_entry_t;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                start      = 1'b0;
  logic                busy;
  enc_in_t             cmd_i      = '0;
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                res_strobe_o;
  enc_out_t            res_o;

  stim_entry_t  instr_queue[$];
  enc_out_t     expected_bytes[$];
  logic [3:0]   prefix_fn_q     = PrefixFnRst;
  logic [3:0]   neg_prefix_fn_q = NegPrefixFnRst;
  logic         instr_taken     = 1'b0;
  int unsigned  quiet_cycles    = 0;
  int unsigned  stall_cycles    = 0;
  int unsigned  fail_cnt        = 0;
  int unsigned  gap_odds        = 0;

  nibble_prefix_instruction_encoder u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // expected byte sequence of one instruction under the current prefix functions
  function automatic void encode_instruction(input enc_in_t cmd);
    logic [31:0] rest;
    logic [7:0]  prefixes[$];
    enc_out_t    ob;
    rest = cmd.operand;
    if (rest[31]) begin
      rest = (~rest) >> 4;
      prefixes.push_front({neg_prefix_fn_q, rest[3:0]});
    end
    rest = rest >> 4;
    while (rest != 32'd0) begin
      prefixes.push_front({prefix_fn_q, rest[3:0]});
      rest = rest >> 4;
    end
    foreach (prefixes[k]) begin
      ob.code_byte = prefixes[k];
      ob.last_byte = 1'b0;
      expected_bytes = {expected_bytes, ob};
    end
    ob.code_byte = {cmd.function_code, cmd.operand[3:0]};
    ob.last_byte = 1'b1;
    expected_bytes = {expected_bytes, ob};
  endfunction

  // monitor, predictor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      instr_taken <= start && !busy;
      if (start && !busy) begin
        encode_instruction(cmd_i);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgIdxPrefix: prefix_fn_q = cfg_data_i;
          CfgIdxNegPrefix: neg_prefix_fn_q = cfg_data_i;
          default: ;
        endcase
      end
      if (res_strobe_o) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected byte, expected none, actual %02h last %0b",
                   $time, res_o.code_byte, res_o.last_byte);
          fail_cnt++;
        end else begin
          if (res_o.code_byte !== expected_bytes[0].code_byte) begin
            $display("%0t: code_byte mismatch, expected %02h, actual %02h",
                     $time, expected_bytes[0].code_byte, res_o.code_byte);
            fail_cnt++;
          end
          if (res_o.last_byte !== expected_bytes[0].last_byte) begin
            $display("%0t: last_byte mismatch, expected %0b, actual %0b",
                     $time, expected_bytes[0].last_byte, res_o.last_byte);
            fail_cnt++;
          end
          void'(expected_bytes.pop_front());
        end
      end
      if ((start && !busy) || res_strobe_o || cfg_we_i) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("%0t: watchdog expired", $time);
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  // driver
  always @(negedge clk_i) begin
    logic                start_nx;
    enc_in_t             cmd_nx;
    logic                we_nx;
    logic [CfgIdxW-1:0]  idx_nx;
    logic [CfgDataW-1:0] data_nx;
    start_nx = 1'b0;
    cmd_nx   = cmd_i;
    we_nx    = 1'b0;
    idx_nx   = cfg_idx_i;
    data_nx  = cfg_data_i;
    if (rst_ni) begin
      if (instr_taken) begin
        void'(instr_queue.pop_front());
      end
      if (expected_bytes.size() == 0 && !start && !cfg_we_i) begin
        quiet_cycles++;
      end else begin
        quiet_cycles = 0;
      end
      if (instr_queue.size() != 0) begin
        case (instr_queue[0].kind)
          EntItem: begin
            start_nx = 1'b1;
            cmd_nx   = instr_queue[0].cmd;
          end
          EntIdle: begin
            if (instr_queue[0].count <= 1) begin
              void'(instr_queue.pop_front());
            end else begin
              instr_queue[0].count--;
            end
          end
          EntCfg: begin
            if (quiet_cycles >= SettleCycles) begin
              we_nx   = 1'b1;
              idx_nx  = instr_queue[0].idx;
              data_nx = instr_queue[0].data;
              void'(instr_queue.pop_front());
            end
          end
          default: ;
        endcase
      end
    end
    start      <= start_nx;
    cmd_i      <= cmd_nx;
    cfg_we_i   <= we_nx;
    cfg_idx_i  <= idx_nx;
    cfg_data_i <= data_nx;
  end

  function automatic logic [31:0] random_operand();
    logic [31:0] v;
    int unsigned nibs;
    v = $urandom;
    if ($urandom_range(0, 3) != 0) begin
      nibs = $urandom_range(0, 8);
      if (nibs < 8) begin
        v = v & ((32'd1 << (4 * nibs)) - 32'd1);
      end
      if ($urandom_range(0, 1) == 1) begin
        v = ~v;
      end
    end
    return v;
  endfunction

  task automatic push_item(input logic [3:0] fn, input logic [31:0] operand);
    stim_entry_t e;
    e.idx  = '0;
    e.data = '0;
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      e.kind  = EntIdle;
      e.cmd   = '0;
      e.count = $urandom_range(1, 16);
      instr_queue = {instr_queue, e};
    end
    e.kind              = EntItem;
    e.cmd.function_code = fn;
    e.cmd.operand       = operand;
    e.count             = 0;
    instr_queue = {instr_queue, e};
  endtask

  task automatic push_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    stim_entry_t e;
    e.kind  = EntCfg;
    e.cmd   = '0;
    e.idx   = idx;
    e.data  = data;
    e.count = 0;
    instr_queue = {instr_queue, e};
  endtask

  initial begin
    logic [31:0] corner_ops [20];
    logic [3:0]  pre_set [6];
    logic [3:0]  neg_set [6];
    corner_ops = '{32'h0000_0000, 32'h0000_0001, 32'h0000_000F, 32'h0000_0010,
                   32'h0000_00FF, 32'h0000_0100, 32'hFFFF_FFFF, 32'hFFFF_FFF0,
                   32'hFFFF_FFEF, 32'hFFFF_FF00, 32'hFFFF_FEFF, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h0FFF_FFFF, 32'h1000_0000, 32'hF000_0000,
                   32'hF7FF_FFFF, 32'h1234_5678, 32'hA5A5_A5A5, 32'h0000_8000};
    pre_set = '{4'h0, 4'hF, 4'(($urandom)), 4'hF, 4'(($urandom)), PrefixFnRst};
    neg_set = '{4'h0, 4'hF, 4'(($urandom)), 4'h0, 4'(($urandom)), NegPrefixFnRst};

    // corner operands under reset configuration, every function code
    gap_odds = 4;
    for (int i = 0; i < 20; i++) begin
      push_item(4'((i * 7) % 16), corner_ops[i]);
    end
    push_item(4'hF, 32'h0000_0000);
    push_item(4'h0, 32'hFFFF_FFFF);

    for (int p = 0; p < 6; p++) begin
      push_cfg(CfgIdxPrefix, pre_set[p]);
      push_cfg(CfgIdxNegPrefix, neg_set[p]);
      // bursty phases, one gapless phase, a phase whose second half has no gaps, clean tail
      gap_odds = (p == 5) ? 0 : (p == 2) ? 0 : 3;
      for (int i = 0; i < PhaseItems; i++) begin
        if (p == 3 && i == PhaseItems / 2) begin
          gap_odds = 0;
        end
        push_item(4'($urandom), random_operand());
      end
    end

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    while (instr_queue.size() != 0 || expected_bytes.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(negedge clk_i);

    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
